@@ src/pcm_gain_ramp_macros.svh @@
// Assertion macros shared by the pcm_gain_ramp RTL.
// Each macro uses the module's clock and reset ports by name.
`ifndef PCM_GAIN_RAMP_MACROS_SVH
`define PCM_GAIN_RAMP_MACROS_SVH

// Same-cycle implication.
`define PGR_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PGR_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/pgr_pkg.sv @@
// Package for the PCM gain ramp: widths, register indexes, FSM state and
// the command/status structs between controller and datapath. No dependencies.
`default_nettype none

package pgr_pkg;

   localparam int MAX_FRAMES   = 4096;
   localparam int MAX_CHANNELS = 8;
   localparam int SAMPLE_BITS  = 24;

   localparam int GAIN_W      = 16;
   localparam int LEN_W       = 13;
   localparam int CHAN_W      = 4;
   localparam int ENABLE_W    = 1;
   localparam int FRAME_IDX_W = $clog2(MAX_FRAMES);
   localparam int CHAN_IDX_W  = $clog2(MAX_CHANNELS);

   // Gain in Q2.31: Q1.15 shifted up by 16.
   localparam int GAIN_SHIFT = 16;
   localparam int ACC_W      = 34;
   localparam int PROD_W     = SAMPLE_BITS + ACC_W;
   localparam int RND_SHIFT  = 31;
   localparam int Q_W        = PROD_W - RND_SHIFT;

   // Step divider: |end - start| << 16 over the frame length.
   localparam int QUOT_W    = GAIN_W + GAIN_SHIFT;
   localparam int DIV_CNT_W = $clog2(QUOT_W);
   localparam int REM_W     = LEN_W;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = LEN_W;

   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_LENGTH  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_CHANNEL_COUNT = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_ENABLE   = 2'd2;

   localparam logic [LEN_W-1:0]    FRAME_LENGTH_RST  = LEN_W'(480);
   localparam logic [CHAN_W-1:0]   CHANNEL_COUNT_RST = CHAN_W'(2);
   localparam logic [ENABLE_W-1:0] GAIN_ENABLE_RST   = 1'b1;

   localparam int START_LSB   = SAMPLE_BITS;
   localparam int END_LSB     = SAMPLE_BITS + GAIN_W;
   localparam int REQ_FIELD_W = SAMPLE_BITS + 2 * GAIN_W;
   localparam int REQ_TDATA_W = ((REQ_FIELD_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_MUL,
      S_OUT
   } pgr_state_type;

   typedef struct packed {
      logic accept;
      logic div_step;
      logic compute;
      logic load_out;
   } pgr_cmd_type;

   typedef struct packed {
      logic buf_start;
      logic div_done;
   } pgr_sts_type;

endpackage

`default_nettype wire

@@ src/pcm_gain_ramp.sv @@
// PCM gain ramp: scales interleaved Q0.23 samples by a linear Q1.15 gain
// ramp that runs from start_gain to end_gain over one buffer of frame_length
// frames of channel_count channels; both gains are taken from the first sample
// of a buffer, and every sample of a frame gets the same gain. A buffer whose
// gains are both zero is muted and flagged on rsp_tuser while gain_enable is
// set; req_tuser zeroes one sample. Scaled results are rounded and saturated.
// A sample is registered when it is accepted, multiplied in S_MUL and loaded
// into the output register in S_OUT, and then the next sample can be taken;
// the first sample of a buffer also passes through S_DIV while the per-frame
// step is found by a restoring divider at one quotient bit per cycle over 32
// bits. One sample is in work at a time; the output register lets the next
// sample enter while a result waits, and that sample then holds until the
// waiting result is taken. Uses pgr_pkg, pgr_ctrl and pgr_datapath.
`default_nettype none

module pcm_gain_ramp (
   input  logic                             clock,
   input  logic                             reset,
   // csr_addr: 0 frame_length, 1 channel_count, 2 gain_enable
   input  logic                             csr_we,
   input  logic [pgr_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [pgr_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // req_tdata: sample_in [23:0], start_gain [39:24], end_gain [55:40]
   input  logic [pgr_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // req_tuser: force_silence
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // rsp_tdata: sample_out [23:0]
   output logic [pgr_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // rsp_tuser: buffer_silent
   output logic                             rsp_tuser,
   output logic                             rsp_tlast
);
   import pgr_pkg::*;

   pgr_cmd_type cmd;
   pgr_sts_type sts;

   pgr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   pgr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

endmodule

`default_nettype wire

@@ src/pgr_ctrl.sv @@
// Controller FSM of the PCM gain ramp: sequences accept, step division,
// multiply and output load. Uses pgr_pkg and pcm_gain_ramp_macros.svh.
`default_nettype none
`include "pcm_gain_ramp_macros.svh"

module pgr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  pgr_pkg::pgr_sts_type sts,
   output pgr_pkg::pgr_cmd_type cmd
);
   import pgr_pkg::*;

   pgr_state_type state_ff;
   pgr_state_type state_in;
   logic          out_valid_ff;
   logic          out_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = sts.buf_start ? S_DIV : S_MUL;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.compute = 1'b1;
            state_in    = S_OUT;
         end
         S_OUT: begin
            // hold until the output register is free or being drained
            if (!out_valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      out_valid_in = cmd.load_out | (out_valid_ff & ~rsp_tready);
   end

   assign rsp_tvalid = out_valid_ff;

   `PGR_ASSERT_NXT(a_start_divides, cmd.accept && sts.buf_start, state_ff == S_DIV, "buffer start skipped step division")
   `PGR_ASSERT_IMP(a_valid_from_out, $rose(rsp_tvalid), $past(state_ff == S_OUT), "result raised outside output state")

endmodule

`default_nettype wire

@@ src/pgr_datapath.sv @@
// Datapath of the PCM gain ramp: config registers, buffer position, step
// divider, gain accumulator, multiplier and output register. Uses pgr_pkg.
`default_nettype none
`include "pcm_gain_ramp_macros.svh"

module pgr_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [pgr_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [pgr_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic [pgr_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic                              req_tuser,
   input  pgr_pkg::pgr_cmd_type              cmd,
   output pgr_pkg::pgr_sts_type              sts,
   output logic [pgr_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tuser,
   output logic                              rsp_tlast
);
   import pgr_pkg::*;

   localparam logic [LEN_W-1:0]  FL_MAX = LEN_W'(MAX_FRAMES);
   localparam logic [CHAN_W-1:0] CC_MAX = CHAN_W'(MAX_CHANNELS);
   localparam logic signed [PROD_W-1:0] RND_ADD = PROD_W'(64'd1) << (RND_SHIFT - 1);
   localparam logic [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // configuration
   logic [LEN_W-1:0]    frame_length_ff,  frame_length_in;
   logic [CHAN_W-1:0]   channel_count_ff, channel_count_in;
   logic                gain_enable_ff,   gain_enable_in;

   // buffer state
   logic [FRAME_IDX_W-1:0]  frame_index_ff,   frame_index_in;
   logic [CHAN_IDX_W-1:0]   channel_index_ff, channel_index_in;
   logic signed [ACC_W-1:0] gain_acc_ff,      gain_acc_in;
   logic signed [ACC_W-1:0] gain_step_ff,     gain_step_in;
   logic                    silent_flag_ff,   silent_flag_in;

   // divider
   logic [QUOT_W-1:0]    div_quo_ff, div_quo_in;
   logic [REM_W-1:0]     div_rem_ff, div_rem_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic                 div_neg_ff, div_neg_in;

   // sample path
   logic signed [SAMPLE_BITS-1:0] sample_ff,  sample_in;
   logic signed [PROD_W-1:0]      product_ff, product_in;
   logic                          pass_ff,    pass_in;
   logic                          mute_ff,    mute_in;
   logic                          last_ff,    last_in;
   logic [SAMPLE_BITS-1:0]        out_sample_ff, out_sample_in;
   logic                          out_silent_ff, out_silent_in;
   logic                          out_last_ff,   out_last_in;

   // combinational helpers
   logic [LEN_W-1:0]       fl;
   logic [CHAN_W-1:0]      cc;
   logic [GAIN_W-1:0]      start_gain;
   logic [GAIN_W-1:0]      end_gain;
   logic [GAIN_W-1:0]      gain_mag;
   logic [REM_W:0]         trial;
   logic [REM_W:0]         trial_sub;
   logic                   trial_ge;
   logic [QUOT_W-1:0]      quo_next;
   logic signed [ACC_W-1:0] quo_ext;
   logic                   chan_wrap;
   logic                   frame_wrap;
   logic signed [PROD_W-1:0] rounded;
   logic [Q_W-1:0]         q;
   logic [Q_W-SAMPLE_BITS:0] q_hi;
   logic [SAMPLE_BITS-1:0] scaled;

   always_comb begin
      fl = (frame_length_ff == '0) ? LEN_W'(1) :
           (frame_length_ff > FL_MAX) ? FL_MAX : frame_length_ff;
      cc = (channel_count_ff == '0) ? CHAN_W'(1) :
           (channel_count_ff > CC_MAX) ? CC_MAX : channel_count_ff;

      start_gain = req_tdata[START_LSB +: GAIN_W];
      end_gain   = req_tdata[END_LSB +: GAIN_W];
      gain_mag   = (end_gain < start_gain) ? (start_gain - end_gain) : (end_gain - start_gain);

      // one restoring division bit per cycle
      trial     = {div_rem_ff, div_quo_ff[QUOT_W-1]};
      trial_ge  = trial >= {1'b0, fl};
      trial_sub = trial - {1'b0, fl};
      quo_next  = {div_quo_ff[QUOT_W-2:0], trial_ge};
      quo_ext   = $signed({{(ACC_W-QUOT_W){1'b0}}, quo_next});

      chan_wrap  = ({1'b0, channel_index_ff} + (CHAN_IDX_W+1)'(1)) >= (CHAN_IDX_W+1)'(cc);
      frame_wrap = ({1'b0, frame_index_ff} + LEN_W'(1)) >= fl;

      // round half up, then saturate
      rounded = product_ff + RND_ADD;
      q       = rounded[PROD_W-1:RND_SHIFT];
      q_hi    = q[Q_W-1:SAMPLE_BITS-1];
      if ((&q_hi) || !(|q_hi)) begin
         scaled = q[SAMPLE_BITS-1:0];
      end else begin
         scaled = q[Q_W-1] ? SMIN : SMAX;
      end

      sts.buf_start = (frame_index_ff == '0) && (channel_index_ff == '0);
      sts.div_done  = (div_cnt_ff == '1);
   end

   always_comb begin
      frame_length_in  = frame_length_ff;
      channel_count_in = channel_count_ff;
      gain_enable_in   = gain_enable_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_FRAME_LENGTH:  frame_length_in  = csr_wdata[LEN_W-1:0];
            CSR_CHANNEL_COUNT: channel_count_in = csr_wdata[CHAN_W-1:0];
            CSR_GAIN_ENABLE:   gain_enable_in   = csr_wdata[0];
            default: begin
               // unmapped index: drop
            end
         endcase
      end

      frame_index_in   = frame_index_ff;
      channel_index_in = channel_index_ff;
      gain_acc_in      = gain_acc_ff;
      gain_step_in     = gain_step_ff;
      silent_flag_in   = silent_flag_ff;
      div_quo_in       = div_quo_ff;
      div_rem_in       = div_rem_ff;
      div_cnt_in       = div_cnt_ff;
      div_neg_in       = div_neg_ff;
      sample_in        = sample_ff;
      product_in       = product_ff;
      pass_in          = pass_ff;
      mute_in          = mute_ff;
      last_in          = last_ff;
      out_sample_in    = out_sample_ff;
      out_silent_in    = out_silent_ff;
      out_last_in      = out_last_ff;

      if (cmd.accept) begin
         sample_in = req_tuser ? '0 : $signed(req_tdata[SAMPLE_BITS-1:0]);
         if (sts.buf_start) begin
            gain_acc_in    = $signed({{(ACC_W-GAIN_W-GAIN_SHIFT){1'b0}}, start_gain,
                                      {GAIN_SHIFT{1'b0}}});
            silent_flag_in = (start_gain == '0) && (end_gain == '0);
            div_quo_in     = {gain_mag, {GAIN_SHIFT{1'b0}}};
            div_rem_in     = '0;
            div_cnt_in     = '0;
            div_neg_in     = end_gain < start_gain;
         end
      end

      if (cmd.div_step) begin
         div_rem_in = trial_ge ? trial_sub[REM_W-1:0] : trial[REM_W-1:0];
         div_quo_in = quo_next;
         div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
         if (sts.div_done) begin
            gain_step_in = div_neg_ff ? -quo_ext : quo_ext;
         end
      end

      if (cmd.compute) begin
         product_in = sample_ff * gain_acc_ff;
         pass_in    = !gain_enable_ff;
         mute_in    = gain_enable_ff && silent_flag_ff;
         last_in    = chan_wrap && frame_wrap;
         // advance position; step the gain once per frame
         if (chan_wrap) begin
            channel_index_in = '0;
            if (frame_wrap) begin
               frame_index_in = '0;
            end else begin
               frame_index_in = frame_index_ff + FRAME_IDX_W'(1);
               gain_acc_in    = gain_acc_ff + gain_step_ff;
            end
         end else begin
            channel_index_in = channel_index_ff + CHAN_IDX_W'(1);
         end
      end

      if (cmd.load_out) begin
         if (pass_ff) begin
            out_sample_in = sample_ff;
         end else if (mute_ff) begin
            out_sample_in = '0;
         end else begin
            out_sample_in = scaled;
         end
         out_silent_in = mute_ff;
         out_last_in   = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff  <= FRAME_LENGTH_RST;
         channel_count_ff <= CHANNEL_COUNT_RST;
         gain_enable_ff   <= GAIN_ENABLE_RST;
         frame_index_ff   <= '0;
         channel_index_ff <= '0;
         gain_acc_ff      <= '0;
         gain_step_ff     <= '0;
         silent_flag_ff   <= 1'b0;
         div_cnt_ff       <= '0;
         out_silent_ff    <= 1'b0;
      end else begin
         frame_length_ff  <= frame_length_in;
         channel_count_ff <= channel_count_in;
         gain_enable_ff   <= gain_enable_in;
         frame_index_ff   <= frame_index_in;
         channel_index_ff <= channel_index_in;
         gain_acc_ff      <= gain_acc_in;
         gain_step_ff     <= gain_step_in;
         silent_flag_ff   <= silent_flag_in;
         div_cnt_ff       <= div_cnt_in;
         out_silent_ff    <= out_silent_in;
      end
   end

   always_ff @(posedge clock) begin
      div_quo_ff    <= div_quo_in;
      div_rem_ff    <= div_rem_in;
      div_neg_ff    <= div_neg_in;
      sample_ff     <= sample_in;
      product_ff    <= product_in;
      pass_ff       <= pass_in;
      mute_ff       <= mute_in;
      last_ff       <= last_in;
      out_sample_ff <= out_sample_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_tdata = RSP_TDATA_W'(out_sample_ff);
   assign rsp_tuser = out_silent_ff;
   assign rsp_tlast = out_last_ff;

   `PGR_ASSERT_NXT(a_step_sign, cmd.div_step && sts.div_done && div_neg_ff, gain_step_ff[ACC_W-1] || (gain_step_ff == '0), "falling ramp produced a positive step")
   `PGR_ASSERT_IMP(a_silent_zero, out_silent_ff, out_sample_ff == '0, "silent result carries a nonzero sample")

endmodule

`default_nettype wire
